// ----- hw/rtl/fskr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fskr_pkg
// shared types and constants of the fsk edge count receiver
// ----------------------------------------------------------------------------
package fskr_pkg;

  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned InTdataW    = 8;
  localparam int unsigned OutTdataW   = 40;
  localparam int unsigned LowRunW     = 18;
  localparam int unsigned IdleSymbols = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYMBOL_TICKS        = 3'd0,
    REG_EXPECTED_EDGES_ZERO = 3'd1,
    REG_EXPECTED_EDGES_ONE  = 3'd2,
    REG_SYMBOLS_PER_CAPTURE = 3'd3,
    REG_SEARCH_TIMEOUT      = 3'd4
  } cfg_reg_e;

  localparam logic [15:0] RstSymbolTicks       = 16'd1000;
  localparam logic [15:0] RstExpectedEdgesZero = 16'd20;
  localparam logic [15:0] RstExpectedEdgesOne  = 16'd40;
  localparam logic [15:0] RstSymbolsPerCapture = 16'd1;
  localparam logic [31:0] RstSearchTimeout     = 32'd0;

  typedef struct packed {
    logic [15:0] symbol_ticks;
    logic [15:0] expected_edges_zero;
    logic [15:0] expected_edges_one;
    logic [15:0] symbols_per_capture;
    logic [31:0] search_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic        status;
    logic [15:0] edge_count;
    logic        decided_bit;
    logic [15:0] symbol_index;
    logic        last;
  } res_t;

endpackage

// ----- hw/rtl/fskr_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fskr_core
// start search, window edge counts, bit decision, one sample per enabled cycle
// ----------------------------------------------------------------------------
module fskr_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           sample_en_i,
  input  logic           line_level_i,
  input  fskr_pkg::cfg_t cfg_i,
  output logic           res_valid_o,
  output fskr_pkg::res_t res_o
);
  import fskr_pkg::*;

  logic               capturing_q, capturing_d;
  logic               armed_q, armed_d;
  logic               prev_level_q, prev_level_d;
  logic [LowRunW-1:0] low_run_q, low_run_d;
  logic [31:0]        elapsed_q, elapsed_d;
  logic [15:0]        win_tick_q, win_tick_d;
  logic [15:0]        win_edges_q, win_edges_d;
  logic [15:0]        sym_done_q, sym_done_d;

  logic [15:0]        len;
  logic [15:0]        cnt;
  logic [LowRunW-1:0] idle;
  logic [LowRunW-1:0] low_run_inc;
  logic               start;
  logic [31:0]        elapsed_inc;
  logic               timed_out;
  logic [15:0]        wt;
  logic [15:0]        we;
  logic [15:0]        sd;
  logic [15:0]        edges_n;
  logic [15:0]        wt_n;
  logic               win_end;
  logic               final_sym;
  logic [15:0]        d0;
  logic [15:0]        d1;

  assign len  = (cfg_i.symbol_ticks == '0) ? 16'd1 : cfg_i.symbol_ticks;
  assign cnt  = (cfg_i.symbols_per_capture == '0) ? 16'd1 : cfg_i.symbols_per_capture;
  assign idle = LowRunW'(len) * LowRunW'(IdleSymbols);
  assign low_run_inc = (low_run_q < idle) ? low_run_q + 1'b1 : low_run_q;
  assign start = !capturing_q && line_level_i && armed_q && !prev_level_q;
  assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
  assign timed_out = !capturing_q && !start && (cfg_i.search_timeout_ticks != '0) &&
                     (elapsed_inc >= cfg_i.search_timeout_ticks);

  // window datapath, the start tick is tick 0 of the first window
  assign wt = start ? '0 : win_tick_q;
  assign we = start ? '0 : win_edges_q;
  assign sd = start ? '0 : sym_done_q;

  always_comb begin
    edges_n = we;
    if (wt == '0) begin
      edges_n = '0;
    end else if (line_level_i != prev_level_q && we != '1) begin
      edges_n = we + 1'b1;
    end
  end

  assign wt_n      = (wt != '1) ? wt + 1'b1 : wt;
  assign win_end   = (capturing_q || start) && (wt_n >= len);
  assign final_sym = ({1'b0, sd} + 17'd1) >= {1'b0, cnt};
  assign d0 = (edges_n >= cfg_i.expected_edges_zero) ? edges_n - cfg_i.expected_edges_zero
                                                     : cfg_i.expected_edges_zero - edges_n;
  assign d1 = (edges_n >= cfg_i.expected_edges_one) ? edges_n - cfg_i.expected_edges_one
                                                    : cfg_i.expected_edges_one - edges_n;

  always_comb begin
    capturing_d  = capturing_q;
    armed_d      = armed_q;
    prev_level_d = line_level_i;
    low_run_d    = low_run_q;
    elapsed_d    = elapsed_q;
    win_tick_d   = win_tick_q;
    win_edges_d  = win_edges_q;
    sym_done_d   = sym_done_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (!capturing_q && !start) begin
      if (!line_level_i) begin
        low_run_d = low_run_inc;
        if (low_run_inc >= idle) begin
          armed_d = 1'b1;
        end
      end else begin
        low_run_d = '0;
      end
      elapsed_d = elapsed_inc;
      if (timed_out) begin
        res_valid_o  = 1'b1;
        res_o.status = 1'b1;
        res_o.last   = 1'b1;
        armed_d      = 1'b0;
        low_run_d    = '0;
        elapsed_d    = '0;
        sym_done_d   = '0;
      end
    end else begin
      capturing_d = 1'b1;
      win_tick_d  = wt_n;
      win_edges_d = edges_n;
      sym_done_d  = sd;
      if (win_end) begin
        res_valid_o        = 1'b1;
        res_o.edge_count   = edges_n;
        res_o.decided_bit  = d1 < d0;
        res_o.symbol_index = sd;
        res_o.last         = final_sym;
        win_tick_d         = '0;
        win_edges_d        = '0;
        if (final_sym) begin
          capturing_d = 1'b0;
          armed_d     = 1'b0;
          low_run_d   = '0;
          elapsed_d   = '0;
          sym_done_d  = '0;
        end else if (sd != '1) begin
          sym_done_d = sd + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q  <= 1'b0;
      armed_q      <= 1'b0;
      prev_level_q <= 1'b0;
      low_run_q    <= '0;
      elapsed_q    <= '0;
      win_tick_q   <= '0;
      win_edges_q  <= '0;
      sym_done_q   <= '0;
    end else if (sample_en_i) begin
      capturing_q  <= capturing_d;
      armed_q      <= armed_d;
      prev_level_q <= prev_level_d;
      low_run_q    <= low_run_d;
      elapsed_q    <= elapsed_d;
      win_tick_q   <= win_tick_d;
      win_edges_q  <= win_edges_d;
      sym_done_q   <= sym_done_d;
    end
  end

`ifndef SYNTHESIS
  a_capture_armed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    capturing_q |-> armed_q)
    else $error("capture running without armed flag");

  a_search_window_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !capturing_q |-> (win_tick_q == '0 && win_edges_q == '0 && sym_done_q == '0))
    else $error("window state not clear while searching");

  a_edges_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_edges_q <= win_tick_q)
    else $error("more edges than ticks in window");

  a_timeout_enabled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status) |-> (cfg_i.search_timeout_ticks != '0 && !capturing_q))
    else $error("timeout result with timeout disabled");
`endif

endmodule

// ----- hw/rtl/fsk_edge_count_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsk_edge_count_receiver
// fsk receiver that decides each symbol by counting line level changes
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one line sample per transaction (tdata bit 0).
//   The block waits for four symbol windows of low line, then the first rising
//   edge starts a capture of symbols_per_capture windows. At each window end
//   one transaction leaves on the master stream with the edge count, the
//   decided bit and the symbol index; tlast marks the final symbol. A search
//   timeout gives one transaction with tuser set and tlast set. Throughput is
//   one sample per cycle unless stalled. A result appears on the master side
//   in the cycle after the sample that closes its window, held in a single
//   output register; s_axis_tready_o drops only while that register is full
//   and m_axis_tready_i is low, so the sample stream stalls with the receiver.
//   The configuration channel always accepts and writes the register given by
//   cfg_index_i; writes belong to idle periods. Reset restores the register
//   defaults (1000, 20, 40, 1, 0), clears the search and empties the output.
// ----------------------------------------------------------------------------
module fsk_edge_count_receiver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [fskr_pkg::InTdataW-1:0]      s_axis_tdata_i,  // line_level
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // edge_count, decided_bit, symbol_index, zero fill
  output logic [fskr_pkg::OutTdataW-1:0]     m_axis_tdata_o,
  output logic                               m_axis_tuser_o,  // status
  output logic                               m_axis_tlast_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fskr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [fskr_pkg::CfgDataW-1:0]      cfg_data_i
);
  import fskr_pkg::*;

  cfg_t cfg_q;
  logic sample_en;
  logic res_valid;
  res_t res;
  logic out_valid_q;
  res_t out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.symbol_ticks         <= RstSymbolTicks;
      cfg_q.expected_edges_zero  <= RstExpectedEdgesZero;
      cfg_q.expected_edges_one   <= RstExpectedEdgesOne;
      cfg_q.symbols_per_capture  <= RstSymbolsPerCapture;
      cfg_q.search_timeout_ticks <= RstSearchTimeout;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SYMBOL_TICKS:        cfg_q.symbol_ticks         <= cfg_data_i[15:0];
        REG_EXPECTED_EDGES_ZERO: cfg_q.expected_edges_zero  <= cfg_data_i[15:0];
        REG_EXPECTED_EDGES_ONE:  cfg_q.expected_edges_one   <= cfg_data_i[15:0];
        REG_SYMBOLS_PER_CAPTURE: cfg_q.symbols_per_capture  <= cfg_data_i[15:0];
        REG_SEARCH_TIMEOUT:      cfg_q.search_timeout_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign sample_en       = s_axis_tvalid_i && s_axis_tready_o;

  fskr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_en_i  (sample_en),
    .line_level_i (s_axis_tdata_i[0]),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sample_en) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_en && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {(OutTdataW - 33)'(0), out_q.symbol_index, out_q.decided_bit,
                            out_q.edge_count};

`ifndef SYNTHESIS
  a_timeout_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tlast_o && m_axis_tdata_o == '0))
    else $error("timeout transaction with payload or without tlast");
`endif

endmodule
